// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LTSC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while in reset
`define LTSC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/ltsc_pkg.sv =====
// Shared constants and types of the LRU/TTL/byte-budget cache policy block.
// No dependencies.
package ltsc_pkg;

	localparam int NUM_ENTRIES = 64;
	localparam int SLOT_W      = $clog2(NUM_ENTRIES);
	localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
	localparam int KEY_W       = 64;

	// operation codes
	localparam logic [1:0] OP_GET   = 2'd0;
	localparam logic [1:0] OP_PUT   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_MISS    = 3'd1;
	localparam logic [2:0] ST_EXPIRED = 3'd2;
	localparam logic [2:0] ST_MODIFIED= 3'd3;
	localparam logic [2:0] ST_STORED  = 3'd4;
	localparam logic [2:0] ST_REJECT  = 3'd5;

	// config register indexes
	localparam logic [1:0] CFG_MAX_TOTAL = 2'd0;
	localparam logic [1:0] CFG_MAX_ENTRY = 2'd1;
	localparam logic [1:0] CFG_TTL       = 2'd2;

	localparam logic [31:0] RST_MAX_TOTAL = 32'(64 * 1024 * 1024);
	localparam logic [24:0] RST_MAX_ENTRY = 25'(1024 * 1024);
	localparam logic [15:0] RST_TTL       = 16'd60;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// one stored entry
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [31:0]      mtime;
		logic [32:0]      expiry;
		logic [24:0]      size;
		slot_t            rank;
	} entry_t;

	// one result word
	typedef struct packed {
		logic        hit;
		slot_t       slot;
		logic [2:0]  status;
		cnt_t        evicted_now;
		logic [32:0] occupied_bytes;
		cnt_t        entry_count;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] eviction_count;
		logic [31:0] expiration_count;
	} result_t;

endpackage

// ===== rtl/ltsc_if.sv =====
// Valid/ready channel interfaces for the query and result words.
// Depends on ltsc_pkg.
interface ltsc_query_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 op;
	logic [ltsc_pkg::KEY_W-1:0] key_id;
	logic [31:0]                file_mtime;
	logic [15:0]                header_bytes;
	logic [23:0]                body_bytes;
	logic [31:0]                now_seconds;

	modport source (output valid, op, key_id, file_mtime, header_bytes, body_bytes,
		now_seconds, input ready);
	modport sink (input valid, op, key_id, file_mtime, header_bytes, body_bytes,
		now_seconds, output ready);
endinterface

interface ltsc_result_if;
	logic                  valid;
	logic                  ready;
	logic                  hit;
	ltsc_pkg::slot_t       slot;
	logic [2:0]            status;
	ltsc_pkg::cnt_t        evicted_now;
	logic [32:0]           occupied_bytes;
	ltsc_pkg::cnt_t        entry_count;
	logic [31:0]           hit_count;
	logic [31:0]           miss_count;
	logic [31:0]           eviction_count;
	logic [31:0]           expiration_count;

	modport source (output valid, hit, slot, status, evicted_now, occupied_bytes,
		entry_count, hit_count, miss_count, eviction_count, expiration_count, input ready);
	modport sink (input valid, hit, slot, status, evicted_now, occupied_bytes,
		entry_count, hit_count, miss_count, eviction_count, expiration_count, output ready);
endinterface

// ===== rtl/lru_ttl_size_cache_policy.sv =====
// Top level: LRU cache policy with time-to-live and byte budget.
// Depends on ltsc_pkg and ltsc_if (ltsc_query_if, ltsc_result_if).
//
//  channel   dir  word                                   handshake
//  query     in   op, key, mtime, sizes, current time    valid/ready
//  result    out  hit, slot, status, stats               valid/ready
//  cfg       in   register index and data                write enable only
//
// Each word walks the entry memory in sweeps over all NUM_ENTRIES slots (one read
// port, registered read). A get takes 2 sweeps on a hit or drop, 1 on a miss;
// a put takes 1 lookup sweep, 1 more if the key was held, 1 per eviction and 1
// insert sweep, plus control states. Clear and rejects take no sweep.
// Reset clears valid bits and counters at once; no memory clearing pass.
// A stalled result is held in its register; the next query is taken meanwhile.
module lru_ttl_size_cache_policy (
	input  logic                clk,
	input  logic                arst_n,
	ltsc_query_if.sink          query,
	ltsc_result_if.source       result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ltsc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_FIND  = 4'd1;
	localparam logic [3:0] S_DROP  = 4'd2;
	localparam logic [3:0] S_PROMO = 4'd3;
	localparam logic [3:0] S_EVCHK = 4'd4;
	localparam logic [3:0] S_EVICT = 4'd5;
	localparam logic [3:0] S_INS   = 4'd6;
	localparam logic [3:0] S_WRITE = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	localparam cnt_t NE = CNT_W'(NUM_ENTRIES);

	logic [3:0]  state_q;

	// config registers
	logic [31:0] max_total_q;
	logic [24:0] max_entry_q;
	logic [15:0] ttl_q;

	// entry memory and its read stage
	entry_t      mem [NUM_ENTRIES];
	entry_t      rd_s1;
	logic        p_s1;
	slot_t       pidx_s1;
	cnt_t        idx_q;
	logic [NUM_ENTRIES-1:0] valid_q;

	// current word
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [31:0]      mtime_q;
	logic [31:0]      now_q;
	logic [24:0]      size_q;

	// stats
	logic [32:0] bytes_q;
	cnt_t        count_q;
	logic [31:0] hits_q, misses_q, evicts_q, expires_q;

	// per-word scratch
	logic        found_q;
	slot_t       fslot_q;
	slot_t       frank_q;
	logic [24:0] fsize_q;
	logic [31:0] fmtime_q;
	logic [32:0] fexp_q;
	slot_t       ref_q;
	logic        free_found_q;
	slot_t       free_q;
	cnt_t        evn_q;
	logic        hit_q;
	slot_t       slot_q;
	logic [2:0]  status_q;

	result_t     res_q;
	logic        rvalid_q;

	logic        sweep, done, cur_valid, fits;
	logic [24:0] new_size;
	slot_t       wslot;
	logic        mem_we;
	slot_t       mem_waddr;
	entry_t      mem_wdata;

	assign sweep = (state_q == S_FIND) || (state_q == S_DROP) || (state_q == S_PROMO)
		|| (state_q == S_EVICT) || (state_q == S_INS);
	assign done      = sweep && (idx_q == NE) && !p_s1;
	assign cur_valid = valid_q[pidx_s1];
	assign new_size  = {9'd0, query.header_bytes} + {1'b0, query.body_bytes};
	assign wslot     = free_found_q ? free_q : '0;
	assign fits      = ({1'b0, bytes_q} + {9'd0, size_q}) <= {2'b0, max_total_q};

	assign query.ready = (state_q == S_IDLE);

	// memory write-back of the sweep and the final insert
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pidx_s1;
		mem_wdata = rd_s1;
		case (state_q)
			S_DROP: begin
				if (p_s1 && cur_valid && rd_s1.rank > ref_q) begin
					mem_we         = 1'b1;
					mem_wdata.rank = rd_s1.rank - 1'b1;
				end
			end
			S_PROMO: begin
				if (p_s1 && pidx_s1 == fslot_q) begin
					mem_we         = 1'b1;
					mem_wdata.rank = '0;
				end else if (p_s1 && cur_valid && rd_s1.rank < ref_q) begin
					mem_we         = 1'b1;
					mem_wdata.rank = rd_s1.rank + 1'b1;
				end
			end
			S_INS: begin
				if (p_s1 && cur_valid) begin
					mem_we         = 1'b1;
					mem_wdata.rank = rd_s1.rank + 1'b1;
				end
			end
			S_WRITE: begin
				mem_we           = 1'b1;
				mem_waddr        = wslot;
				mem_wdata.key    = key_q;
				mem_wdata.mtime  = mtime_q;
				mem_wdata.expiry = {1'b0, now_q} + {17'd0, ttl_q};
				mem_wdata.size   = size_q;
				mem_wdata.rank   = '0;
			end
			default: ;
		endcase
	end

	// entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rd_s1 <= mem[idx_q[SLOT_W-1:0]];
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_total_q <= RST_MAX_TOTAL;
			max_entry_q <= RST_MAX_ENTRY;
			ttl_q       <= RST_TTL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_TOTAL: max_total_q <= cfg_data;
				CFG_MAX_ENTRY: max_entry_q <= cfg_data[24:0];
				CFG_TTL:       ttl_q       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// sweep address and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s1    <= 1'b0;
			pidx_s1 <= '0;
		end else begin
			p_s1    <= sweep && (idx_q < NE);
			pidx_s1 <= idx_q[SLOT_W-1:0];
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			valid_q      <= '0;
			bytes_q      <= '0;
			count_q      <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			evicts_q     <= '0;
			expires_q    <= '0;
			op_q         <= OP_NOP;
			key_q        <= '0;
			mtime_q      <= '0;
			now_q        <= '0;
			size_q       <= '0;
			found_q      <= 1'b0;
			fslot_q      <= '0;
			frank_q      <= '0;
			fsize_q      <= '0;
			fmtime_q     <= '0;
			fexp_q       <= '0;
			ref_q        <= '0;
			free_found_q <= 1'b0;
			free_q       <= '0;
			evn_q        <= '0;
			hit_q        <= 1'b0;
			slot_q       <= '0;
			status_q     <= ST_MISS;
			res_q        <= '0;
			rvalid_q     <= 1'b0;
		end else begin
			if (sweep && idx_q < NE)
				idx_q <= idx_q + 1'b1;
			// result register: load a new word or retire the taken one
			if (state_q == S_FIN && (!rvalid_q || result.ready))
				rvalid_q <= 1'b1;
			else if (result.ready)
				rvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (query.valid) begin
						op_q         <= query.op;
						key_q        <= query.key_id;
						mtime_q      <= query.file_mtime;
						now_q        <= query.now_seconds;
						size_q       <= new_size;
						evn_q        <= '0;
						hit_q        <= 1'b0;
						slot_q       <= '0;
						status_q     <= ST_MISS;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						idx_q        <= '0;
						case (query.op)
							OP_GET: state_q <= S_FIND;
							OP_PUT: begin
								if (new_size > max_entry_q) begin
									status_q <= ST_REJECT;
									state_q  <= S_FIN;
								end else begin
									state_q <= S_FIND;
								end
							end
							OP_CLEAR: begin
								valid_q   <= '0;
								bytes_q   <= '0;
								count_q   <= '0;
								hits_q    <= '0;
								misses_q  <= '0;
								evicts_q  <= '0;
								expires_q <= '0;
								status_q  <= ST_REJECT;
								state_q   <= S_FIN;
							end
							default: state_q <= S_FIN;
						endcase
					end
				end

				S_FIND: begin
					if (p_s1 && cur_valid && rd_s1.key == key_q && !found_q) begin
						found_q  <= 1'b1;
						fslot_q  <= pidx_s1;
						frank_q  <= rd_s1.rank;
						fsize_q  <= rd_s1.size;
						fmtime_q <= rd_s1.mtime;
						fexp_q   <= rd_s1.expiry;
					end
					if (done) begin
						idx_q <= '0;
						if (op_q == OP_GET) begin
							if (!found_q) begin
								misses_q <= misses_q + 1'b1;
								state_q  <= S_FIN;
							end else if ({1'b0, now_q} > fexp_q || fmtime_q != mtime_q) begin
								// expired or modified: drop the entry
								misses_q <= misses_q + 1'b1;
								if ({1'b0, now_q} > fexp_q) begin
									expires_q <= expires_q + 1'b1;
									status_q  <= ST_EXPIRED;
								end else begin
									status_q <= ST_MODIFIED;
								end
								valid_q[fslot_q] <= 1'b0;
								bytes_q <= bytes_q - {8'd0, fsize_q};
								count_q <= count_q - 1'b1;
								ref_q   <= frank_q;
								state_q <= S_DROP;
							end else begin
								hits_q   <= hits_q + 1'b1;
								hit_q    <= 1'b1;
								slot_q   <= fslot_q;
								status_q <= ST_HIT;
								ref_q    <= frank_q;
								state_q  <= S_PROMO;
							end
						end else if (found_q) begin
							// replace: drop old copy, no eviction counted
							valid_q[fslot_q] <= 1'b0;
							bytes_q <= bytes_q - {8'd0, fsize_q};
							count_q <= count_q - 1'b1;
							ref_q   <= frank_q;
							state_q <= S_DROP;
						end else begin
							state_q <= S_EVCHK;
						end
					end
				end

				S_DROP: begin
					if (done)
						state_q <= (op_q == OP_GET) ? S_FIN : S_EVCHK;
				end

				S_PROMO: begin
					if (done)
						state_q <= S_FIN;
				end

				// evict the LRU entry until the new entry fits and a slot is free
				S_EVCHK: begin
					idx_q <= '0;
					if (count_q == '0 || (fits && count_q < NE)) begin
						free_found_q <= 1'b0;
						state_q      <= S_INS;
					end else begin
						ref_q    <= SLOT_W'(count_q - 1'b1);
						evicts_q <= evicts_q + 1'b1;
						evn_q    <= evn_q + 1'b1;
						state_q  <= S_EVICT;
					end
				end

				S_EVICT: begin
					if (p_s1 && cur_valid && rd_s1.rank == ref_q) begin
						valid_q[pidx_s1] <= 1'b0;
						bytes_q <= bytes_q - {8'd0, rd_s1.size};
						count_q <= count_q - 1'b1;
					end
					if (done)
						state_q <= S_EVCHK;
				end

				// age all entries and find the first free slot
				S_INS: begin
					if (p_s1 && !cur_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_q       <= pidx_s1;
					end
					if (done)
						state_q <= S_WRITE;
				end

				S_WRITE: begin
					valid_q[wslot] <= 1'b1;
					bytes_q  <= bytes_q + {8'd0, size_q};
					count_q  <= count_q + 1'b1;
					slot_q   <= wslot;
					status_q <= ST_STORED;
					state_q  <= S_FIN;
				end

				S_FIN: begin
					if (!rvalid_q || result.ready) begin
						res_q.hit              <= hit_q;
						res_q.slot             <= slot_q;
						res_q.status           <= status_q;
						res_q.evicted_now      <= evn_q;
						res_q.occupied_bytes   <= bytes_q;
						res_q.entry_count      <= count_q;
						res_q.hit_count        <= hits_q;
						res_q.miss_count       <= misses_q;
						res_q.eviction_count   <= evicts_q;
						res_q.expiration_count <= expires_q;
						state_q                <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result port
	assign result.valid            = rvalid_q;
	assign result.hit              = res_q.hit;
	assign result.slot             = res_q.slot;
	assign result.status           = res_q.status;
	assign result.evicted_now      = res_q.evicted_now;
	assign result.occupied_bytes   = res_q.occupied_bytes;
	assign result.entry_count      = res_q.entry_count;
	assign result.hit_count        = res_q.hit_count;
	assign result.miss_count       = res_q.miss_count;
	assign result.eviction_count   = res_q.eviction_count;
	assign result.expiration_count = res_q.expiration_count;

endmodule

// ===== rtl/ltsc_checker.sv =====
// Port-level checks of the cache policy block, bound to the top level.
// Depends on ltsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ltsc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 rsp_hit,
	input logic [2:0]           rsp_status,
	input ltsc_pkg::cnt_t       rsp_evicted,
	input ltsc_pkg::cnt_t       rsp_count
);
	import ltsc_pkg::*;

	// a stalled result word stays up and its status unchanged
	`LTSC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`LTSC_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status), "status changed while stalled")
	// only a get hit reports hit
	`LTSC_ASSERT_IMP(a_hit_status, rsp_valid && rsp_hit, rsp_status == ST_HIT, "hit without hit status")
	// evictions only come with a stored put that leaves the table non-empty
	`LTSC_ASSERT_IMP(a_evict_put, rsp_valid && rsp_evicted != '0, rsp_status == ST_STORED && rsp_count != '0, "eviction outside a put")
endmodule

bind lru_ttl_size_cache_policy ltsc_checker u_ltsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (result.valid),
	.rsp_ready   (result.ready),
	.rsp_hit     (result.hit),
	.rsp_status  (result.status),
	.rsp_evicted (result.evicted_now),
	.rsp_count   (result.entry_count)
);
